// ===== rtl/core/lpfr_pkg.sv =====
package lpfr_pkg;

    // framing constants
    localparam int HEADER_BYTES = 4;
    localparam int HDR_CNT_W    = 3;
    localparam int LEN_W        = 32;

    // input beat modes
    localparam logic [1:0] MODE_DATA  = 2'd0;
    localparam logic [1:0] MODE_OPEN  = 2'd1;
    localparam logic [1:0] MODE_CLOSE = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_BYTE    = 3'd0;
    localparam logic [2:0] KIND_EMPTY   = 3'd1;
    localparam logic [2:0] KIND_OPENED  = 3'd2;
    localparam logic [2:0] KIND_CLOSED  = 3'd3;
    localparam logic [2:0] KIND_DISCARD = 3'd4;

    // reset value of the body length limit
    localparam logic [LEN_W-1:0] MAX_BODY_RESET = 32'd16777216;

    // result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] channel_tag;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_out;
        logic       frame_end;
        logic       protocol_error;
        logic       last_of_run;
    } out_beat_t;

    // up to two results produced by one input beat
    typedef struct packed {
        logic [1:0] count;
        out_beat_t  first;
        out_beat_t  second;
    } res_push_t;

    function automatic out_beat_t make_res(
        input logic [2:0] kind,
        input logic [7:0] byte_out,
        input logic       frame_end,
        input logic       protocol_error,
        input logic       last_of_run
    );
        out_beat_t r;
        r.kind           = kind;
        r.byte_out       = byte_out;
        r.frame_end      = frame_end;
        r.protocol_error = protocol_error;
        r.last_of_run    = last_of_run;
        return r;
    endfunction

endpackage

// ===== rtl/core/length_prefixed_frame_receiver.sv =====
// Length-prefixed frame receiver.
// Input channel (s_valid/s_ready/s_data) carries one beat per item: a data
// byte, a channel open or a channel close, each tagged with a channel. Frames
// are a 4-byte little-endian length followed by that many body bytes; body
// bytes come out one per beat as they arrive, the last marked frame_end.
// Result channel (m_valid/m_ready/m_data) carries up to two beats per input
// item; last_of_run marks the final one. cfg_wr_en/cfg_wr_data write the
// body length limit. A result passes through the input register, then the
// deframer writes it into a four-entry result queue, which offers it.
// Throughput: one input beat per cycle while results drain one per cycle; a
// beat that yields two results leaves one extra entry in the queue.
// Reset (aresetn low, synchronous) closes the channel, clears framing, empties
// the queue and restores the limit to 16777216. When the result side stalls
// the queue fills, and s_ready drops once the input register holds a beat and
// fewer than two queue entries are free.
module length_prefixed_frame_receiver (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lpfr_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lpfr_pkg::out_beat_t  m_data
);

    logic                beat_valid;
    lpfr_pkg::in_beat_t  beat_data;
    logic                room;
    logic                go;
    lpfr_pkg::res_push_t push;

    // process the held beat when the queue can take two results
    assign go = beat_valid && room;

    lpfr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (go),
        .beat_valid (beat_valid),
        .beat_data  (beat_data)
    );

    lpfr_deframer u_deframer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .go          (go),
        .beat        (beat_data),
        .push        (push)
    );

    lpfr_out_queue u_out_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef ASSERT_OFF
    // results are only produced for a beat that is being consumed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> go)
        else $error("results pushed without a consumed beat");

    // the only result that is not last of its run is a discard
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last_of_run) |-> (m_data.kind == lpfr_pkg::KIND_DISCARD))
        else $error("non-final result is not a discard");

    // frame end only marks body bytes and empty frames
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_end) |->
            (m_data.kind == lpfr_pkg::KIND_BYTE || m_data.kind == lpfr_pkg::KIND_EMPTY))
        else $error("frame end on a non-body result");

    // queue is empty right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");
`endif

endmodule

// ===== rtl/core/lpfr_in_stage.sv =====
module lpfr_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lpfr_pkg::in_beat_t s_data,
    input  logic               take,
    output logic               beat_valid,
    output lpfr_pkg::in_beat_t beat_data
);

    logic               valid_reg;
    logic               valid_next;
    lpfr_pkg::in_beat_t data_reg;

    // register frees up when the held beat is consumed
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign beat_valid = valid_reg;
    assign beat_data  = data_reg;

endmodule

// ===== rtl/core/lpfr_deframer.sv =====
module lpfr_deframer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data,
    input  logic                  go,
    input  lpfr_pkg::in_beat_t    beat,
    output lpfr_pkg::res_push_t   push
);

    localparam int LW = lpfr_pkg::LEN_W;
    localparam int CW = lpfr_pkg::HDR_CNT_W;

    logic [LW-1:0] max_body_reg;
    logic          open_reg,       open_next;
    logic [7:0]    tag_reg,        tag_next;
    logic          broken_reg,     broken_next;
    logic [CW-1:0] hdr_cnt_reg,    hdr_cnt_next;
    logic [LW-1:0] length_reg,     length_next;
    logic [LW-1:0] remaining_reg,  remaining_next;
    logic          started_reg,    started_next;

    logic          current;
    logic          hdr_done;
    logic [LW-1:0] len_asm;
    logic [LW-1:0] rem_dec;
    logic [CW-1:0] hdr_cnt_inc;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_body_reg <= lpfr_pkg::MAX_BODY_RESET;
        end else if (cfg_wr_en) begin
            max_body_reg <= cfg_wr_data;
        end
    end

    assign current     = open_reg && (beat.channel_tag == tag_reg);
    assign hdr_done    = (hdr_cnt_reg == CW'(lpfr_pkg::HEADER_BYTES));
    assign rem_dec     = remaining_reg - LW'(1);
    assign hdr_cnt_inc = hdr_cnt_reg + CW'(1);

    // drop the incoming byte into its lane of the length word
    always_comb begin
        len_asm = length_reg;
        len_asm[8*hdr_cnt_reg[1:0] +: 8] = beat.data_byte;
    end

    // next state and results for one beat
    always_comb begin
        open_next      = open_reg;
        tag_next       = tag_reg;
        broken_next    = broken_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        started_next   = started_reg;
        push.count     = 2'd0;
        push.first     = '0;
        push.second    = '0;

        case (beat.mode)
            lpfr_pkg::MODE_OPEN: begin
                if (started_reg) begin
                    push.count  = 2'd2;
                    push.first  = lpfr_pkg::make_res(lpfr_pkg::KIND_DISCARD, 8'd0,
                                                     1'b0, 1'b0, 1'b0);
                    push.second = lpfr_pkg::make_res(lpfr_pkg::KIND_OPENED, 8'd0,
                                                     1'b0, 1'b0, 1'b1);
                end else begin
                    push.count = 2'd1;
                    push.first = lpfr_pkg::make_res(lpfr_pkg::KIND_OPENED, 8'd0,
                                                    1'b0, 1'b0, 1'b1);
                end
                open_next      = 1'b1;
                tag_next       = beat.channel_tag;
                broken_next    = 1'b0;
                hdr_cnt_next   = '0;
                length_next    = '0;
                remaining_next = '0;
                started_next   = 1'b0;
            end
            lpfr_pkg::MODE_CLOSE: begin
                if (current) begin
                    if (started_reg && !broken_reg) begin
                        push.count  = 2'd2;
                        push.first  = lpfr_pkg::make_res(lpfr_pkg::KIND_DISCARD, 8'd0,
                                                         1'b0, 1'b0, 1'b0);
                        push.second = lpfr_pkg::make_res(lpfr_pkg::KIND_CLOSED, 8'd0,
                                                         1'b0, 1'b0, 1'b1);
                    end else if (started_reg) begin
                        push.count = 2'd1;
                        push.first = lpfr_pkg::make_res(lpfr_pkg::KIND_DISCARD, 8'd0,
                                                        1'b0, 1'b0, 1'b1);
                    end else if (!broken_reg) begin
                        push.count = 2'd1;
                        push.first = lpfr_pkg::make_res(lpfr_pkg::KIND_CLOSED, 8'd0,
                                                        1'b0, 1'b0, 1'b1);
                    end
                    open_next      = 1'b0;
                    hdr_cnt_next   = '0;
                    length_next    = '0;
                    remaining_next = '0;
                    started_next   = 1'b0;
                end
            end
            lpfr_pkg::MODE_DATA: begin
                if (current && !broken_reg) begin
                    if (!hdr_done) begin
                        // gathering the length header
                        length_next  = len_asm;
                        hdr_cnt_next = hdr_cnt_inc;
                        if (hdr_cnt_inc == CW'(lpfr_pkg::HEADER_BYTES)) begin
                            if (len_asm > max_body_reg) begin
                                broken_next    = 1'b1;
                                hdr_cnt_next   = '0;
                                length_next    = '0;
                                remaining_next = '0;
                                started_next   = 1'b0;
                                push.count     = 2'd1;
                                push.first     = lpfr_pkg::make_res(
                                    lpfr_pkg::KIND_CLOSED, 8'd0, 1'b0, 1'b1, 1'b1);
                            end else if (len_asm == '0) begin
                                hdr_cnt_next   = '0;
                                length_next    = '0;
                                remaining_next = '0;
                                started_next   = 1'b0;
                                push.count     = 2'd1;
                                push.first     = lpfr_pkg::make_res(
                                    lpfr_pkg::KIND_EMPTY, 8'd0, 1'b1, 1'b0, 1'b1);
                            end else begin
                                remaining_next = len_asm;
                                started_next   = 1'b0;
                            end
                        end
                    end else begin
                        // body byte passes straight through
                        push.count = 2'd1;
                        if (rem_dec == '0) begin
                            hdr_cnt_next   = '0;
                            length_next    = '0;
                            remaining_next = '0;
                            started_next   = 1'b0;
                            push.first     = lpfr_pkg::make_res(
                                lpfr_pkg::KIND_BYTE, beat.data_byte, 1'b1, 1'b0, 1'b1);
                        end else begin
                            remaining_next = rem_dec;
                            started_next   = 1'b1;
                            push.first     = lpfr_pkg::make_res(
                                lpfr_pkg::KIND_BYTE, beat.data_byte, 1'b0, 1'b0, 1'b1);
                        end
                    end
                end
            end
            default: begin
                // unused mode, no effect
            end
        endcase

        if (!go) begin
            push.count = 2'd0;
        end
    end

    // framing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg      <= 1'b0;
            tag_reg       <= '0;
            broken_reg    <= 1'b0;
            hdr_cnt_reg   <= '0;
            length_reg    <= '0;
            remaining_reg <= '0;
            started_reg   <= 1'b0;
        end else if (go) begin
            open_reg      <= open_next;
            tag_reg       <= tag_next;
            broken_reg    <= broken_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
            started_reg   <= started_next;
        end
    end

endmodule

// ===== rtl/core/lpfr_out_queue.sv =====
module lpfr_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lpfr_pkg::res_push_t  push,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lpfr_pkg::out_beat_t  m_data
);

    localparam int PW = lpfr_pkg::Q_PTR_W;
    localparam int CW = lpfr_pkg::Q_CNT_W;

    lpfr_pkg::out_beat_t entries [lpfr_pkg::Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          pop;
    logic [PW-1:0] wr_ptr_plus1;

    // room for a full pair of results
    assign room         = (count_reg <= CW'(lpfr_pkg::Q_DEPTH - 2));
    assign m_valid      = (count_reg != '0);
    assign m_data       = entries[rd_ptr_reg];
    assign pop          = m_valid && m_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);

    assign wr_ptr_next = wr_ptr_reg + PW'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + CW'(push.count) - CW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entries[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entries[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

// ===== verif/lpfr_frame_checker.sv =====
`timescale 1ns / 1ps

module lpfr_frame_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  lpfr_pkg::in_beat_t   s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  lpfr_pkg::out_beat_t  m_data,
    output int                   fail_count,
    output int                   pending
);

    // shadow copy of the receiver state and its length limit
    logic        link_up;
    logic [7:0]  link_tag;
    logic        jammed;
    int          hdr_seen;
    logic [31:0] len_acc;
    logic [31:0] body_left;
    logic        body_out;
    logic [31:0] body_limit;

    // result beats still owed by the block, oldest first
    lpfr_pkg::out_beat_t frame_results_q[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        fail_count++;
        $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got_v, want_v);
    endtask

    function automatic lpfr_pkg::out_beat_t beat_of(input logic [2:0] kind,
                                                    input logic [7:0] dat,
                                                    input logic fin, input logic err);
        lpfr_pkg::out_beat_t r;
        r.kind           = kind;
        r.byte_out       = dat;
        r.frame_end      = fin;
        r.protocol_error = err;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    task automatic clear_framing();
        hdr_seen  = 0;
        len_acc   = '0;
        body_left = '0;
        body_out  = 1'b0;
    endtask

    // work out the results one input beat causes and advance the shadow state
    task automatic predict_deframe(input lpfr_pkg::in_beat_t b);
        lpfr_pkg::out_beat_t made [2];
        int                  n;
        logic                on_link;
        n = 0;
        on_link = link_up && (b.channel_tag == link_tag);
        case (b.mode)
            lpfr_pkg::MODE_OPEN: begin
                if (body_out) begin
                    made[n] = beat_of(lpfr_pkg::KIND_DISCARD, 8'h00, 1'b0, 1'b0);
                    n++;
                end
                link_up  = 1'b1;
                link_tag = b.channel_tag;
                jammed   = 1'b0;
                clear_framing();
                made[n] = beat_of(lpfr_pkg::KIND_OPENED, 8'h00, 1'b0, 1'b0);
                n++;
            end
            lpfr_pkg::MODE_CLOSE: begin
                if (on_link) begin
                    if (body_out) begin
                        made[n] = beat_of(lpfr_pkg::KIND_DISCARD, 8'h00, 1'b0, 1'b0);
                        n++;
                    end
                    link_up = 1'b0;
                    clear_framing();
                    // a broken channel already reported its close
                    if (!jammed) begin
                        made[n] = beat_of(lpfr_pkg::KIND_CLOSED, 8'h00, 1'b0, 1'b0);
                        n++;
                    end
                end
            end
            lpfr_pkg::MODE_DATA: begin
                if (on_link && !jammed) begin
                    if (hdr_seen < lpfr_pkg::HEADER_BYTES) begin
                        // little-endian length assembly
                        len_acc = len_acc | (32'(b.data_byte) << (8 * hdr_seen));
                        hdr_seen++;
                        if (hdr_seen == lpfr_pkg::HEADER_BYTES) begin
                            if (len_acc > body_limit) begin
                                jammed = 1'b1;
                                clear_framing();
                                made[n] = beat_of(lpfr_pkg::KIND_CLOSED, 8'h00, 1'b0, 1'b1);
                                n++;
                            end else if (len_acc == 0) begin
                                clear_framing();
                                made[n] = beat_of(lpfr_pkg::KIND_EMPTY, 8'h00, 1'b1, 1'b0);
                                n++;
                            end else begin
                                body_left = len_acc;
                                body_out  = 1'b0;
                            end
                        end
                    end else begin
                        body_left = body_left - 1;
                        if (body_left == 0) begin
                            clear_framing();
                            made[n] = beat_of(lpfr_pkg::KIND_BYTE, b.data_byte, 1'b1, 1'b0);
                        end else begin
                            body_out = 1'b1;
                            made[n] = beat_of(lpfr_pkg::KIND_BYTE, b.data_byte, 1'b0, 1'b0);
                        end
                        n++;
                    end
                end
            end
            default: ;
        endcase
        if (n > 0)
            made[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            frame_results_q.push_back(made[i]);
    endtask

    // compare one delivered result with the oldest one owed
    task automatic check_result(input lpfr_pkg::out_beat_t got);
        lpfr_pkg::out_beat_t want;
        if (frame_results_q.size() == 0) begin
            report_mismatch("unexpected result beat", 32'(got), 32'h0);
        end else begin
            want = frame_results_q.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", 32'(got.kind), 32'(want.kind));
            if (got.byte_out !== want.byte_out)
                report_mismatch("byte_out", 32'(got.byte_out), 32'(want.byte_out));
            if (got.frame_end !== want.frame_end)
                report_mismatch("frame_end", 32'(got.frame_end), 32'(want.frame_end));
            if (got.protocol_error !== want.protocol_error)
                report_mismatch("protocol_error", 32'(got.protocol_error),
                                32'(want.protocol_error));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
        end
    endtask

    // watch both channels and the limit register
    always @(posedge aclk) begin
        if (!aresetn) begin
            link_up    = 1'b0;
            link_tag   = 8'h00;
            jammed     = 1'b0;
            body_limit = lpfr_pkg::MAX_BODY_RESET;
            clear_framing();
            frame_results_q.delete();
        end else begin
            if (cfg_wr_en)
                body_limit = cfg_wr_data;
            if (s_valid && s_ready)
                predict_deframe(s_data);
            if (m_valid && m_ready)
                check_result(m_data);
        end
        pending = frame_results_q.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] MODE_RSVD  = 2'd3;
    localparam int         IDLE_LIMIT = 5000;
    localparam int         PHASE_BEATS = 115;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [31:0]         cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    lpfr_pkg::in_beat_t  s_data;
    logic                m_valid;
    logic                m_ready;
    lpfr_pkg::out_beat_t m_data;
    int                  fail_count;
    int                  pending;

    // stimulus bookkeeping
    logic [7:0]  live_tag;
    int          dense_left;
    int          useful;
    bit          noise_on;
    bit          squeeze_req;
    int          idle_cycles;

    length_prefixed_frame_receiver DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    lpfr_frame_checker frame_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // offer one beat, hold it until taken, then maybe idle
    task automatic offer(input logic [1:0] m, input logic [7:0] tag, input logic [7:0] dat);
        lpfr_pkg::in_beat_t beat;
        int                 gap;
        beat.mode        = m;
        beat.channel_tag = tag;
        beat.data_byte   = dat;
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (dense_left > 0) begin
            dense_left--;
            gap = 0;
        end else begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // one beat of the frame stream, sometimes preceded by a stray beat
    task automatic flow(input logic [1:0] m, input logic [7:0] tag, input logic [7:0] dat);
        logic [7:0] other;
        if (noise_on && $urandom_range(0, 9) == 0) begin
            other = 8'($urandom);
            if (other == live_tag)
                other = other ^ 8'h01;
            case ($urandom_range(0, 2))
                0:       offer(MODE_RSVD, 8'($urandom), 8'($urandom));
                1:       offer(lpfr_pkg::MODE_DATA, other, 8'($urandom));
                default: offer(lpfr_pkg::MODE_CLOSE, other, 8'($urandom));
            endcase
        end
        if (m == lpfr_pkg::MODE_OPEN)
            live_tag = tag;
        offer(m, tag, dat);
        useful++;
    endtask

    task automatic send_header(input logic [7:0] tag, input logic [31:0] len, input int count);
        for (int i = 0; i < count; i++)
            flow(lpfr_pkg::MODE_DATA, tag, len[8*i +: 8]);
    endtask

    // one frame on the live channel; flags a frame that leaves the link unusable
    task automatic run_frame(input logic [31:0] limit, output bit ended);
        logic [31:0] len;
        int          r;
        int          n;
        ended = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 10)
            len = 0;
        else if (r < 65)
            len = $urandom_range(1, 8);
        else if (r < 75)
            len = $urandom_range(9, 40);
        else if (r < 85)
            len = (limit < 32'hFFFF_FFF0) ? limit + 1 + $urandom_range(0, 3) : $urandom;
        else if (r < 92)
            len = limit;
        else
            len = $urandom;

        // length cut off part way
        if ($urandom_range(0, 19) == 0) begin
            send_header(live_tag, len, $urandom_range(1, 3));
            ended = 1'b1;
            return;
        end
        send_header(live_tag, len, lpfr_pkg::HEADER_BYTES);
        if (len > limit) begin
            ended = 1'b1;
            return;
        end
        if (len == 0)
            return;

        // body, occasionally cut short; a body over 40 bytes is always cut short
        if (len <= 40) begin
            n = len;
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(0, len);
        end else begin
            n = $urandom_range(0, 10);
        end
        ended = (n < len);
        for (int i = 0; i < n; i++)
            flow(lpfr_pkg::MODE_DATA, live_tag, 8'($urandom));
    endtask

    // open, a few frames, then a close or a reopen by the next session
    task automatic run_session(input logic [31:0] limit);
        int frames;
        bit ended;
        int tail;
        if ($urandom_range(0, 5) == 0)
            dense_left = 30;
        flow(lpfr_pkg::MODE_OPEN, 8'($urandom), 8'($urandom));
        frames = $urandom_range(0, 5);
        ended = 1'b0;
        for (int f = 0; f < frames && !ended; f++)
            run_frame(limit, ended);
        tail = $urandom_range(0, 2);
        for (int i = 0; i < tail; i++)
            flow(lpfr_pkg::MODE_DATA, live_tag, 8'($urandom));
        if ($urandom_range(0, 9) < 7)
            flow(lpfr_pkg::MODE_CLOSE, live_tag, 8'($urandom));
    endtask

    // let the block drain before touching the limit or ending
    task automatic drain(input int settle);
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic set_limit(input logic [31:0] v);
        drain(6);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // result side: random ready with gaps, plus long hold-offs on request
    initial begin
        int run;
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
            end else begin
                run = $urandom_range(1, 24);
                m_ready <= 1'b1;
                repeat (run) @(negedge aclk);
                if ($urandom_range(0, 5) != 0) begin
                    stall = pick_gap();
                    if (stall > 0) begin
                        m_ready <= 1'b0;
                        repeat (stall) @(negedge aclk);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("length_prefixed_frame_receiver test failed");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        logic [31:0] phase_limit [7];
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        live_tag    = 8'h00;
        dense_left  = 0;
        useful      = 0;
        noise_on    = 1'b0;
        squeeze_req = 1'b0;
        idle_cycles = 0;
        phase_limit = '{lpfr_pkg::MAX_BODY_RESET, 32'd0, 32'hFFFF_FFFF, 32'd3, 32'd40,
                        lpfr_pkg::MAX_BODY_RESET, 32'($urandom_range(1, 30))};
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: ignored beats while closed
        flow(lpfr_pkg::MODE_DATA, 8'h00, 8'hFF);
        flow(lpfr_pkg::MODE_CLOSE, 8'h00, 8'h00);
        flow(MODE_RSVD, 8'hFF, 8'hFF);
        // empty frame, then a two-byte frame
        flow(lpfr_pkg::MODE_OPEN, 8'hFF, 8'h00);
        send_header(8'hFF, 32'd0, lpfr_pkg::HEADER_BYTES);
        send_header(8'hFF, 32'd2, lpfr_pkg::HEADER_BYTES);
        flow(lpfr_pkg::MODE_DATA, 8'hFF, 8'h00);
        flow(lpfr_pkg::MODE_DATA, 8'hFF, 8'hFF);
        // body under way, reopen gives discard then opened
        send_header(8'hFF, 32'd5, lpfr_pkg::HEADER_BYTES);
        flow(lpfr_pkg::MODE_DATA, 8'hFF, 8'hA5);
        flow(lpfr_pkg::MODE_OPEN, 8'h00, 8'hFF);
        // oversized length, then data and close on the broken channel
        send_header(8'h00, 32'h0100_0001, lpfr_pkg::HEADER_BYTES);
        flow(lpfr_pkg::MODE_DATA, 8'h00, 8'h5A);
        flow(lpfr_pkg::MODE_CLOSE, 8'h00, 8'h00);

        // random phases, one limit each
        noise_on = 1'b1;
        for (int p = 0; p < 7; p++) begin
            if (p > 0)
                set_limit(phase_limit[p]);
            if (p == 0 || p == 4) begin
                squeeze_req = 1'b1;
                dense_left  = 80;
            end
            useful = 0;
            while (useful < PHASE_BEATS)
                run_session(phase_limit[p]);
        end

        drain(10);
        if (fail_count == 0 && pending == 0)
            $display("length_prefixed_frame_receiver test passed");
        else
            $display("length_prefixed_frame_receiver test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/lpfr_pkg.sv
rtl/core/lpfr_in_stage.sv
rtl/core/lpfr_deframer.sv
rtl/core/lpfr_out_queue.sv
rtl/core/length_prefixed_frame_receiver.sv
verif/lpfr_frame_checker.sv
verif/tb.sv
